// ----- sv/orf_pkg.sv -----
// Package for the overwriting ring FIFO: sizes, opcodes and index helpers.
// Depends on nothing; used by overwriting_ring_fifo.
package orf_pkg;

    // Storage geometry
    localparam int DEPTH  = 256;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Stream payload widths (padded to whole bytes)
    localparam int OP_W      = 3;
    localparam int S_DATA_W  = ((OP_W + WIDTH + 7) / 8) * 8;
    localparam int M_FIELD_W = WIDTH + CNT_W + 3;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WIDTH-1:0]  word_t;

    // Opcodes carried in the low bits of s_tdata
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_PEEK    = 3'd2,
        OP_POP     = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    // Status carried from the update stage to the output register
    typedef struct packed {
        logic rvalid;
        cnt_t count;
        logic full;
        logic empty;
        logic over;
    } status_t;

    // Step a ring index, wrapping at the capacity in use
    function automatic addr_t ring_adv(input addr_t idx, input cnt_t cap);
        cnt_t nxt;
        nxt = {1'b0, idx} + cnt_t'(1);
        return (nxt >= cap) ? addr_t'(0) : nxt[ADDR_W-1:0];
    endfunction

    // Capacity register to capacity in use: zero acts as one, saturates at DEPTH
    function automatic cnt_t cap_limit(input cnt_t cap);
        if (cap == cnt_t'(0)) begin
            return cnt_t'(1);
        end else if (cap > cnt_t'(DEPTH)) begin
            return cnt_t'(DEPTH);
        end
        return cap;
    endfunction

endpackage

// ----- sv/overwriting_ring_fifo.sv -----
// Overwriting ring FIFO: the slot read and the pending status are registered at the input
// transfer, then move into the result register once the result stream has room.
// Throughput one item per cycle while m_tready stays high; indices update at each
// transfer, so the next item's memory read already sees them.
// Reset (aresetn low, synchronous) empties the FIFO, sets capacity to 100 and drops
// any pending result; slot contents are not cleared. Depends on orf_pkg.
module overwriting_ring_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write: capacity
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  orf_pkg::cnt_t                 cfg_data,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [orf_pkg::S_DATA_W-1:0]  s_tdata,   // opcode, data_in, zero pad
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [orf_pkg::M_DATA_W-1:0]  m_tdata,   // read_data, count, is_full,
                                                     // is_empty, overwrote, zero pad
    output logic                          m_tuser    // read_valid
);
    import orf_pkg::*;

    // Control state
    cnt_t    cap_reg, cap_next;
    addr_t   head_reg, head_next;
    addr_t   tail_reg, tail_next;
    cnt_t    count_reg, count_next;
    logic    empty_reg, empty_next;
    logic    pend_reg;
    logic    m_valid_reg;

    // Payload
    status_t pstat_reg, pstat_next;
    status_t mstat_reg;
    word_t   mdata_reg;
    word_t   rd_data_reg;
    word_t   slots [DEPTH];

    // Memory access controls
    logic    wr_en;
    addr_t   wr_addr;
    logic    rd_en;

    logic    s_xfer;
    logic    cfg_xfer;
    logic    pend_move;
    cnt_t    cap_eff;
    op_t     op;
    word_t   din;

    assign cap_eff   = cap_limit(cap_reg);
    assign op        = op_t'(s_tdata[OP_W-1:0]);
    assign din       = s_tdata[OP_W +: WIDTH];
    assign pend_move = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !pend_reg || pend_move;
    assign s_xfer    = s_tvalid && s_tready;
    // capacity writes only while no item is offered or in flight
    assign cfg_ready = !(pend_reg || m_valid_reg || s_tvalid);
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Per-item state update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        empty_next = empty_reg;
        cap_next   = cap_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_en      = 1'b0;
        pstat_next = '0;
        if (cfg_xfer) begin
            cap_next   = cfg_data;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            empty_next = 1'b1;
        end else if (s_xfer) begin
            case (op)
                OP_PUSH: begin
                    wr_en = 1'b1;
                    if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = cnt_t'(1);
                        empty_next = 1'b0;
                    end else if (count_reg >= cap_eff) begin
                        head_next       = ring_adv(head_reg, cap_eff);
                        tail_next       = ring_adv(tail_reg, cap_eff);
                        pstat_next.over = 1'b1;
                    end else begin
                        tail_next  = ring_adv(tail_reg, cap_eff);
                        count_next = count_reg + cnt_t'(1);
                    end
                    wr_addr = tail_next;
                end
                OP_DEQUEUE, OP_PEEK, OP_POP: begin
                    if (!empty_reg) begin
                        rd_en             = (op != OP_POP);
                        pstat_next.rvalid = (op != OP_POP);
                        if (op != OP_PEEK) begin
                            // drop the oldest entry
                            if (head_reg == tail_reg) begin
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = '0;
                                empty_next = 1'b1;
                            end else begin
                                head_next  = ring_adv(head_reg, cap_eff);
                                count_next = count_reg - cnt_t'(1);
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    empty_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        pstat_next.count = count_next;
        pstat_next.full  = (count_next == cap_eff);
        pstat_next.empty = empty_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= cnt_t'(100);
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            empty_reg   <= 1'b1;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            empty_reg <= empty_next;
            if (s_xfer) begin
                pend_reg <= 1'b1;
            end else if (pend_move) begin
                pend_reg <= 1'b0;
            end
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Slot memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots[wr_addr] <= din;
        end
        if (rd_en) begin
            rd_data_reg <= slots[head_reg];
        end
    end

    // Pending status and output register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pstat_reg <= pstat_next;
        end
        if (pend_move) begin
            mstat_reg <= pstat_reg;
            mdata_reg <= pstat_reg.rvalid ? rd_data_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = mstat_reg.rvalid;
    assign m_tdata  = M_DATA_W'({mstat_reg.over, mstat_reg.empty, mstat_reg.full,
                                 mstat_reg.count, mdata_reg});

    // Occupancy never exceeds the capacity in use
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_eff)
        else $error("occupancy above capacity");

    // Empty mark and occupancy agree
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg == (count_reg == cnt_t'(0)))
        else $error("empty mark disagrees with count");

    // Ring indices stay inside the capacity in use
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, head_reg} < cap_eff) && ({1'b0, tail_reg} < cap_eff))
        else $error("ring index out of range");

    // An accepted item always leaves a pending result
    a_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> pend_reg)
        else $error("accepted item lost");

endmodule

// ----- bench/tb_overwriting_ring_fifo.sv -----
// Self-checking bench for overwriting_ring_fifo: directed and random opcode streams
// over several capacities, with a status predictor and in-order result checking.
// Depends on orf_pkg and overwriting_ring_fifo.
module tb_overwriting_ring_fifo;
    import orf_pkg::*;

    // Opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_NOP_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;

    localparam int SETTLE_CYCLES = 6;
    localparam int N_PHASES = 8;

    // One status result as it travels on the result stream
    typedef struct packed {
        logic  rvalid;
        word_t rdata;
        cnt_t  count;
        logic  full;
        logic  empty;
        logic  over;
    } fifo_status_t;

    // Ring model plus the queue of statuses still owed by the block
    class fifo_scoreboard;
        word_t        slot_mem [DEPTH];
        addr_t        head_idx;
        addr_t        tail_idx;
        bit           empty_mark;
        cnt_t         cap_reg;
        fifo_status_t owed_status [$];
        int unsigned  errors;

        function new();
            cap_reg    = cnt_t'(100);
            errors     = 0;
            make_empty();
        endfunction

        function void make_empty();
            head_idx   = '0;
            tail_idx   = '0;
            empty_mark = 1'b1;
        endfunction

        // zero behaves as one, anything above the built depth saturates
        function int usable_cap();
            if (cap_reg == '0) begin
                return 1;
            end else if (int'(cap_reg) > DEPTH) begin
                return DEPTH;
            end
            return int'(cap_reg);
        endfunction

        function addr_t ring_next(addr_t idx, int lim);
            return (int'(idx) + 1 >= lim) ? addr_t'(0) : addr_t'(int'(idx) + 1);
        endfunction

        function int fill_level(int lim);
            if (empty_mark) begin
                return 0;
            end else if (tail_idx >= head_idx) begin
                return int'(tail_idx) - int'(head_idx) + 1;
            end
            return lim - int'(head_idx) + int'(tail_idx) + 1;
        endfunction

        function void drop_oldest(int lim);
            if (head_idx == tail_idx) begin
                make_empty();
            end else begin
                head_idx = ring_next(head_idx, lim);
            end
        endfunction

        // capacity write also empties the ring
        function void set_capacity(cnt_t value);
            cap_reg = value;
            make_empty();
        endfunction

        function int unsigned pending();
            return owed_status.size();
        endfunction

        // Apply one accepted item and queue the status it should produce
        function void note_item(logic [OP_W-1:0] op, word_t data);
            int           lim;
            int           lvl;
            fifo_status_t st;
            lim = usable_cap();
            st  = '0;
            case (op)
                OP_PUSH: begin
                    if (empty_mark) begin
                        head_idx   = '0;
                        tail_idx   = '0;
                        empty_mark = 1'b0;
                    end else if (fill_level(lim) >= lim) begin
                        head_idx = ring_next(head_idx, lim);
                        tail_idx = ring_next(tail_idx, lim);
                        st.over  = 1'b1;
                    end else begin
                        tail_idx = ring_next(tail_idx, lim);
                    end
                    slot_mem[tail_idx] = data;
                end
                OP_DEQUEUE, OP_PEEK: begin
                    if (!empty_mark) begin
                        st.rvalid = 1'b1;
                        st.rdata  = slot_mem[head_idx];
                        if (op == OP_DEQUEUE) begin
                            drop_oldest(lim);
                        end
                    end
                end
                OP_POP: begin
                    if (!empty_mark) begin
                        drop_oldest(lim);
                    end
                end
                OP_CLEAR: begin
                    make_empty();
                end
                default: begin
                end
            endcase
            lvl      = fill_level(lim);
            st.count = cnt_t'(lvl);
            st.full  = (lvl == lim);
            st.empty = empty_mark;
            owed_status.push_back(st);
        endfunction

        // Compare one delivered status with the oldest owed one
        function void check_status(fifo_status_t got);
            fifo_status_t want;
            if (owed_status.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = owed_status.pop_front();
            if (got.rvalid !== want.rvalid) begin
                $display("%0t: read_valid expected %b actual %b", $time, want.rvalid,
                         got.rvalid);
                errors++;
            end
            if (got.rdata !== want.rdata) begin
                $display("%0t: read_data expected %h actual %h", $time, want.rdata,
                         got.rdata);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count expected %0d actual %0d", $time, want.count,
                         got.count);
                errors++;
            end
            if (got.full !== want.full) begin
                $display("%0t: is_full expected %b actual %b", $time, want.full,
                         got.full);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $display("%0t: is_empty expected %b actual %b", $time, want.empty,
                         got.empty);
                errors++;
            end
            if (got.over !== want.over) begin
                $display("%0t: overwrote expected %b actual %b", $time, want.over,
                         got.over);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    cnt_t                cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    fifo_scoreboard sb;
    bit             tx_steady;
    bit             rx_steady;
    int unsigned    rx_wait;

    // Random phases: capacity, item count, push share in percent, clears allowed
    int phase_cap   [N_PHASES] = '{3, 0, 1, 7, 256, 511, 100, 300};
    int phase_items [N_PHASES] = '{150, 80, 80, 200, 400, 400, 60, 60};
    int phase_push  [N_PHASES] = '{55, 50, 55, 60, 90, 90, 50, 60};
    bit phase_clear [N_PHASES] = '{1, 1, 1, 1, 0, 0, 1, 1};

    overwriting_ring_fifo u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10-unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check each transfer, then, unless rx_steady is set, hold tready low for a random wait
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_status({m_tuser, m_tdata[WIDTH-1:0], m_tdata[WIDTH +: CNT_W],
                             m_tdata[WIDTH+CNT_W], m_tdata[WIDTH+CNT_W+1],
                             m_tdata[WIDTH+CNT_W+2]});
            rx_wait = rx_steady ? 0 : $urandom_range(0, 3);
            if (rx_wait != 0) begin
                m_tready <= 1'b0;
            end
        end else if (!m_tready) begin
            if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_wait == 0) begin
                m_tready <= 1'b1;
            end
        end
    end

    // One input transfer after a random gap
    task automatic send_item(input logic [OP_W-1:0] op, input word_t data);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-OP_W-WIDTH){1'b0}}, data, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, data);
    endtask

    // Stop sending and wait for every owed result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Capacity write while idle
    task automatic write_capacity(input cnt_t value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Opcode mix for random items
    function automatic logic [OP_W-1:0] pick_op(int push_pct, bit allow_clear);
        int unsigned r;
        if ($urandom_range(0, 99) < push_pct) begin
            return OP_PUSH;
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return OP_DEQUEUE;
        end else if (r < 55) begin
            return OP_PEEK;
        end else if (r < 80) begin
            return OP_POP;
        end else if (r < 88 && allow_clear) begin
            return OP_CLEAR;
        end else if (r < 88) begin
            return OP_DEQUEUE;
        end
        return OP_W'($urandom_range(OP_NOP_LO, OP_NOP_HI));
    endfunction

    // Main sequence
    initial begin
        sb        = new();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_wait   = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty reads, extremes of data, no-op codes, clear (capacity 100)
        send_item(OP_DEQUEUE, '0);
        send_item(OP_PEEK, '0);
        send_item(OP_POP, '0);
        send_item(OP_NOP_LO, '1);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, '1);
        send_item(OP_PEEK, '0);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_NOP_HI, 32'hdead_beef);
        send_item(OP_PUSH, 32'ha5a5_5a5a);
        send_item(OP_CLEAR, '1);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_NOP_MID, '0);

        // Capacity one: second push overwrites
        write_capacity(cnt_t'(1));
        send_item(OP_PUSH, 32'h1111_1111);
        send_item(OP_PUSH, 32'h2222_2222);
        send_item(OP_PEEK, '0);
        send_item(OP_DEQUEUE, '0);

        // Capacity zero acts as one
        write_capacity(cnt_t'(0));
        send_item(OP_PUSH, 32'h3333_3333);
        send_item(OP_PUSH, 32'h4444_4444);
        send_item(OP_POP, '0);

        // Capacity two: overwrite across the wrap
        write_capacity(cnt_t'(2));
        send_item(OP_PUSH, 32'h5555_5555);
        send_item(OP_PUSH, 32'h6666_6666);
        send_item(OP_PUSH, 32'h7777_7777);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_DEQUEUE, '0);

        // Random phases, each with its own capacity
        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(cnt_t'(phase_cap[p]));
            for (int i = 0; i < phase_items[p]; i++) begin
                if (i % 50 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                if (i == phase_items[p] / 2) begin
                    drain_results();
                end
                send_item(pick_op(phase_push[p], phase_clear[p]), $urandom);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
